### rtl/kclock_pkg.sv
// Package for the keypad code lock core: key codes, lock modes, result codes.
// Used by keypad_code_lock_fsm_core. No dependencies.
package kclock_pkg;

    // Number of keys in one entry
    localparam int CODE_LEN = 4;
    localparam int POS_W    = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
    localparam int IDX_W    = POS_W + 1;
    localparam int KEY_W    = 4;

    // Master code, zero-extended so every key nibble can be selected
    localparam int MASTER_W     = 16;
    localparam int MASTER_EXT_W = (KEY_W * CODE_LEN > MASTER_W) ? KEY_W * CODE_LEN : MASTER_W;
    localparam int ATTEMPT_W    = 4;
    localparam int CFG_DATA_W   = MASTER_W;

    // Reset values of the configuration registers
    localparam logic [MASTER_W-1:0]  MASTER_CODE_RST  = 16'h1234;
    localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPTS_RST = 4'd3;
    localparam logic [ATTEMPT_W-1:0] MISS_MAX         = 4'd15;

    // Configuration register indexes
    localparam logic CFG_MASTER_CODE  = 1'b0;
    localparam logic CFG_MAX_ATTEMPTS = 1'b1;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_A    = 4'd10;
    localparam logic [KEY_W-1:0] KEY_D    = 4'd13;
    localparam logic [KEY_W-1:0] KEY_STAR = 4'd14;
    localparam logic [KEY_W-1:0] KEY_HASH = 4'd15;

    // Request kinds
    localparam logic REQ_KEY    = 1'b0;
    localparam logic REQ_MASTER = 1'b1;

    // Motor commands
    localparam logic [1:0] MOTOR_NONE  = 2'd0;
    localparam logic [1:0] MOTOR_CLOSE = 2'd1;
    localparam logic [1:0] MOTOR_OPEN  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_KEY_TAKEN  = 3'd0;
    localparam logic [2:0] ST_INCOMPLETE = 3'd1;
    localparam logic [2:0] ST_STORED     = 3'd2;
    localparam logic [2:0] ST_OPENING    = 3'd3;
    localparam logic [2:0] ST_INCORRECT  = 3'd4;
    localparam logic [2:0] ST_LOCKED     = 3'd5;
    localparam logic [2:0] ST_MASTER     = 3'd6;

    // Output mode codes
    localparam logic [1:0] MODE_CODE_OPEN   = 2'd0;
    localparam logic [1:0] MODE_CODE_CLOSED = 2'd1;
    localparam logic [1:0] MODE_CODE_LOCKED = 2'd2;
    localparam logic [1:0] MODE_CODE_MASTER = 2'd3;

    // Lock mode, one-hot
    typedef enum logic [3:0] {
        MODE_OPEN   = 4'b0001,
        MODE_CLOSED = 4'b0010,
        MODE_LOCKED = 4'b0100,
        MODE_MASTER = 4'b1000
    } mode_t;

    typedef logic [KEY_W-1:0] key_t;

    // Encode the one-hot mode into the 2-bit output code
    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] c;
        case (m)
            MODE_OPEN:   c = MODE_CODE_OPEN;
            MODE_CLOSED: c = MODE_CODE_CLOSED;
            MODE_LOCKED: c = MODE_CODE_LOCKED;
            MODE_MASTER: c = MODE_CODE_MASTER;
            default:     c = MODE_CODE_OPEN;
        endcase
        return c;
    endfunction

endpackage

### rtl/keypad_code_lock_fsm_core.sv
// Keypad code lock core: entry ring, user/master code compare, miss lockout.
// Depends on kclock_pkg.
//
// Path from input transaction to result: input register, then result register.
// Throughput: one transaction per cycle while m_tready does not stall the result; the lock
// state updates as each item leaves the input register, so the next item already sees it.
// Reset (aresetn, synchronous, active low): open mode, all slots empty, position 0,
// miss count 0, master code 0x1234, max attempts 3. The user code has no reset.
module keypad_code_lock_fsm_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [kclock_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] key, [7:4] zero
    input  logic [0:0]  s_tuser,   // [0] req_type
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [1:0] mode, [3:2] motor_cmd, [6:4] status, [7] blink
);
    import kclock_pkg::*;

    // Configuration registers
    logic [MASTER_W-1:0]  master_code_reg;
    logic [ATTEMPT_W-1:0] max_attempts_reg;

    // Input register
    logic in_valid_reg;
    logic req_type_reg;
    key_t key_reg;

    // Lock state
    mode_t                mode_reg, mode_next;
    key_t                 slots_reg [CODE_LEN];
    key_t                 slots_next [CODE_LEN];
    logic [POS_W-1:0]     write_pos_reg, write_pos_next;
    key_t                 user_code_reg [CODE_LEN];
    logic [ATTEMPT_W-1:0] miss_count_reg, miss_count_next;

    // Result register
    logic       out_valid_reg;
    logic [7:0] out_data_reg, out_data_next;

    // Decode signals
    logic                    advance;
    logic                    store_code;
    logic                    full;
    logic                    match;
    logic [1:0]              motor;
    logic [2:0]              status;
    logic                    blink;
    logic [ATTEMPT_W-1:0]    miss_inc;
    logic [MASTER_EXT_W-1:0] master_ext;
    key_t                    ordered [CODE_LEN];
    key_t                    want;
    logic [IDX_W-1:0]        idx_sum;

    // Handshake: input register advances when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign master_ext = MASTER_EXT_W'(master_code_reg);
    assign miss_inc   = (miss_count_reg < MISS_MAX) ? miss_count_reg + 1'b1 : miss_count_reg;

    // Entry read from oldest slot: ring index (write_pos + i) mod CODE_LEN
    always_comb begin
        for (int i = 0; i < CODE_LEN; i++) begin
            idx_sum = IDX_W'(write_pos_reg) + IDX_W'(i);
            if (idx_sum >= IDX_W'(CODE_LEN)) begin
                idx_sum = idx_sum - IDX_W'(CODE_LEN);
            end
            ordered[i] = slots_reg[idx_sum[POS_W-1:0]];
        end
    end

    // Entry complete and compare against user or master code
    always_comb begin
        full  = 1'b1;
        match = 1'b1;
        for (int i = 0; i < CODE_LEN; i++) begin
            if (slots_reg[i] == KEY_STAR) begin
                full = 1'b0;
            end
            want = (mode_reg == MODE_CLOSED) ? user_code_reg[i]
                                             : master_ext[KEY_W*(CODE_LEN-1-i) +: KEY_W];
            if (ordered[i] != want) begin
                match = 1'b0;
            end
        end
    end

    // Next-state and result decode
    always_comb begin
        mode_next       = mode_reg;
        slots_next      = slots_reg;
        write_pos_next  = write_pos_reg;
        miss_count_next = miss_count_reg;
        store_code      = 1'b0;
        motor           = MOTOR_NONE;
        status          = ST_KEY_TAKEN;
        blink           = 1'b0;

        if (req_type_reg == REQ_MASTER) begin
            mode_next = MODE_MASTER;
            status    = ST_MASTER;
        end else begin
            blink = (mode_reg == MODE_LOCKED);
            if (key_reg inside {[KEY_A:KEY_D]}) begin
                status = ST_KEY_TAKEN;
            end else if (key_reg != KEY_HASH) begin
                // Typed key or star goes into the ring
                slots_next[write_pos_reg] = key_reg;
                write_pos_next = (write_pos_reg == POS_W'(CODE_LEN-1)) ? '0
                                                                       : write_pos_reg + 1'b1;
            end else if (!full) begin
                status = ST_INCOMPLETE;
                if (mode_reg == MODE_OPEN) begin
                    for (int i = 0; i < CODE_LEN; i++) slots_next[i] = KEY_STAR;
                    write_pos_next = '0;
                end
            end else begin
                // Complete submission always empties the ring
                for (int i = 0; i < CODE_LEN; i++) slots_next[i] = KEY_STAR;
                write_pos_next = '0;
                if (mode_reg == MODE_OPEN) begin
                    store_code      = 1'b1;
                    motor           = MOTOR_CLOSE;
                    status          = ST_STORED;
                    miss_count_next = '0;
                    mode_next       = MODE_CLOSED;
                end else if (match) begin
                    motor     = MOTOR_OPEN;
                    status    = ST_OPENING;
                    mode_next = MODE_OPEN;
                end else if (mode_reg == MODE_CLOSED) begin
                    miss_count_next = miss_inc;
                    if (miss_inc >= max_attempts_reg) begin
                        mode_next = MODE_LOCKED;
                        status    = ST_LOCKED;
                    end else begin
                        status = ST_INCORRECT;
                    end
                end else begin
                    status = ST_INCORRECT;
                end
            end
        end

        out_data_next = {blink, status, motor, mode_code(mode_next)};
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_code_reg  <= MASTER_CODE_RST;
            max_attempts_reg <= MAX_ATTEMPTS_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_MASTER_CODE:  master_code_reg  <= cfg_wdata[MASTER_W-1:0];
                CFG_MAX_ATTEMPTS: max_attempts_reg <= cfg_wdata[ATTEMPT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            req_type_reg <= s_tuser[0];
            key_reg      <= s_tdata[KEY_W-1:0];
        end
    end

    // Lock state update, one item per advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_OPEN;
            write_pos_reg  <= '0;
            miss_count_reg <= '0;
            for (int i = 0; i < CODE_LEN; i++) slots_reg[i] <= KEY_STAR;
        end else if (advance) begin
            mode_reg       <= mode_next;
            write_pos_reg  <= write_pos_next;
            miss_count_reg <= miss_count_next;
            slots_reg      <= slots_next;
        end
    end

    // User code store, no reset
    always_ff @(posedge aclk) begin
        if (advance && store_code) begin
            user_code_reg <= ordered;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef ASSERT_OFF
    // Master event always lands in master mode
    a_master_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (req_type_reg == REQ_MASTER) |=> mode_reg == MODE_MASTER)
        else $error("master event did not enter master mode");

    // A complete submission rewinds the ring
    a_submit_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (req_type_reg == REQ_KEY) && (key_reg == KEY_HASH) && full
        |=> write_pos_reg == '0)
        else $error("ring not rewound after submission");

    // Items handled in locked mode never touch the miss count
    a_locked_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (mode_reg == MODE_LOCKED) |=> $stable(miss_count_reg))
        else $error("miss count changed in locked mode");

    // Close command only comes with a stored code
    a_close_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3:2] == MOTOR_CLOSE) |-> m_tdata[6:4] == ST_STORED)
        else $error("close command without stored code");

    // A result waiting to be taken is not overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !advance)
        else $error("pending result overwritten");
`endif

endmodule
